FILE: rtl/core/rac_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and reset values for the request admission block.
// Used by the register file, the decision engine and the top level; no dependencies.
package rac_pkg;

	localparam int DOMAINS_DEF = 4;

	localparam int TIME_W = 48;

	localparam logic [48:0] WINDOW_MS = 49'd60000;

	localparam logic [63:0] MIN_LO_RST   = 64'd773094115080000;
	localparam logic [63:0] MIN_HI_RST   = 64'd1288490192400000;
	localparam logic [7:0]  LIMIT_RST    = 8'd6;
	localparam logic [15:0] FAIL_RST     = 16'd3;
	localparam logic [30:0] BASE_BO_RST  = 31'd30000;
	localparam logic [30:0] MAX_BO_RST   = 31'd1800000;
	localparam logic [3:0]  ENABLE_RST   = 4'hF;
	localparam logic [31:0] GAP_RST      = 32'd1000;

	typedef enum logic [1:0] {
		OP_QUERY  = 2'd0,
		OP_START  = 2'd1,
		OP_FINISH = 2'd2,
		OP_TICK   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CIRC_CLOSED = 2'd0,
		CIRC_OPEN   = 2'd1,
		CIRC_HALF   = 2'd2
	} circ_t;

	typedef struct packed {
		logic [63:0] min_lo;
		logic [63:0] min_hi;
		logic [7:0]  limit;
		logic [15:0] fail_open;
		logic [30:0] base_bo;
		logic [30:0] max_bo;
		logic [3:0]  enable;
		logic [31:0] gap;
	} cfg_t;

	typedef struct packed {
		op_t         op;
		logic [1:0]  domain;
		logic        success;
		logic [47:0] now_ms;
	} item_t;

	typedef struct packed {
		logic        allowed;
		logic [1:0]  circuit;
		logic [15:0] failure_count;
		logic        busy_res;
	} result_t;

endpackage

FILE: rtl/core/rac_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request items and result items.
// No dependencies.
interface rac_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [1:0]  domain;
	logic        success;
	logic [47:0] now_ms;

	modport source (output valid, output op, output domain, output success,
		output now_ms, input ready);
	modport sink (input valid, input op, input domain, input success,
		input now_ms, output ready);
endinterface

interface rac_res_if;
	logic        valid;
	logic        ready;
	logic        allowed;
	logic [1:0]  circuit;
	logic [15:0] failure_count;
	logic        busy_res;

	modport source (output valid, output allowed, output circuit,
		output failure_count, output busy_res, input ready);
	modport sink (input valid, input allowed, input circuit,
		input failure_count, input busy_res, output ready);
endinterface

FILE: rtl/core/rac_cfg_regs.sv
`timescale 1ns / 1ps
// APB-style configuration register file of the request admission block.
// Depends on rac_pkg for the register layout and reset values.
module rac_cfg_regs import rac_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	typedef enum logic [2:0] {
		REG_MIN_LO    = 3'd0,
		REG_MIN_HI    = 3'd1,
		REG_LIMIT     = 3'd2,
		REG_FAIL_OPEN = 3'd3,
		REG_BASE_BO   = 3'd4,
		REG_MAX_BO    = 3'd5,
		REG_ENABLE    = 3'd6,
		REG_GAP       = 3'd7
	} reg_idx_t;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[5:3]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_lo    <= MIN_LO_RST;
			cfg_q.min_hi    <= MIN_HI_RST;
			cfg_q.limit     <= LIMIT_RST;
			cfg_q.fail_open <= FAIL_RST;
			cfg_q.base_bo   <= BASE_BO_RST;
			cfg_q.max_bo    <= MAX_BO_RST;
			cfg_q.enable    <= ENABLE_RST;
			cfg_q.gap       <= GAP_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_MIN_LO:    cfg_q.min_lo    <= pwdata;
				REG_MIN_HI:    cfg_q.min_hi    <= pwdata;
				REG_LIMIT:     cfg_q.limit     <= pwdata[7:0];
				REG_FAIL_OPEN: cfg_q.fail_open <= pwdata[15:0];
				REG_BASE_BO:   cfg_q.base_bo   <= pwdata[30:0];
				REG_MAX_BO:    cfg_q.max_bo    <= pwdata[30:0];
				REG_ENABLE:    cfg_q.enable    <= pwdata[3:0];
				REG_GAP:       cfg_q.gap       <= pwdata[31:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_MIN_LO:    prdata = cfg_q.min_lo;
			REG_MIN_HI:    prdata = cfg_q.min_hi;
			REG_LIMIT:     prdata = {56'd0, cfg_q.limit};
			REG_FAIL_OPEN: prdata = {48'd0, cfg_q.fail_open};
			REG_BASE_BO:   prdata = {33'd0, cfg_q.base_bo};
			REG_MAX_BO:    prdata = {33'd0, cfg_q.max_bo};
			REG_ENABLE:    prdata = {60'd0, cfg_q.enable};
			REG_GAP:       prdata = {32'd0, cfg_q.gap};
		endcase
	end

endmodule

FILE: rtl/core/rac_engine.sv
`timescale 1ns / 1ps
// Per-domain admission state and the combinational decision and update logic.
// Depends on rac_pkg for the item, result and configuration types.
module rac_engine import rac_pkg::*; #(
	parameter int DOMAINS = DOMAINS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    step,
	input  item_t   item,
	output result_t result
);

	logic [47:0] last_start_q   [DOMAINS];
	logic [47:0] window_start_q [DOMAINS];
	logic [7:0]  window_count_q [DOMAINS];
	circ_t       mode_q         [DOMAINS];
	logic [47:0] opened_q       [DOMAINS];
	logic [31:0] backoff_q      [DOMAINS];
	logic [15:0] fail_q         [DOMAINS];
	logic        in_flight_q;
	logic [1:0]  flight_dom_q;
	logic [47:0] last_any_q;

	logic [47:0] last_start_n   [DOMAINS];
	logic [47:0] window_start_n [DOMAINS];
	logic [7:0]  window_count_n [DOMAINS];
	circ_t       mode_n         [DOMAINS];
	logic [47:0] opened_n       [DOMAINS];
	logic [31:0] backoff_n      [DOMAINS];
	logic [15:0] fail_n         [DOMAINS];
	logic        in_flight_n;
	logic [1:0]  flight_dom_n;
	logic [47:0] last_any_n;

	logic [DOMAINS-1:0] sel;
	logic [DOMAINS-1:0] expired;
	logic [DOMAINS-1:0] win_live;
	logic [DOMAINS-1:0] circ_ok;

	logic        known;
	logic [48:0] now49;
	logic [63:0] pair;
	logic [31:0] interval;
	logic [47:0] cur_ls;
	logic [7:0]  cur_cnt;
	logic        cur_live;
	logic        cur_ok;
	logic        gap_ok;
	logic        int_ok;
	logic        may;
	logic [15:0] fail_inc;
	logic [32:0] bo_raw;
	logic [1:0]  rep_circ;
	logic [15:0] rep_fail;

	assign known = {30'd0, item.domain} < 32'(DOMAINS);
	assign now49 = {1'b0, item.now_ms};
	assign pair  = item.domain[1] ? cfg.min_hi : cfg.min_lo;
	assign interval = item.domain[0] ? pair[63:32] : pair[31:0];

	always_comb begin
		for (int i = 0; i < DOMAINS; i++) begin
			sel[i] = known && ({30'd0, item.domain} == 32'(i));
			expired[i] = now49 >= ({1'b0, opened_q[i]} + {17'd0, backoff_q[i]});
			win_live[i] = (window_start_q[i] != 48'd0) &&
				(now49 < ({1'b0, window_start_q[i]} + WINDOW_MS));
			circ_ok[i] = (mode_q[i] != CIRC_OPEN) || expired[i];
		end
	end

	always_comb begin
		cur_ls   = '0;
		cur_cnt  = '0;
		cur_live = 1'b0;
		cur_ok   = 1'b0;
		for (int i = 0; i < DOMAINS; i++) begin
			if (sel[i]) begin
				cur_ls   = last_start_q[i];
				cur_cnt  = window_count_q[i];
				cur_live = win_live[i];
				cur_ok   = circ_ok[i];
			end
		end
	end

	assign gap_ok = (last_any_q == 48'd0) ||
		(now49 >= ({1'b0, last_any_q} + {17'd0, cfg.gap}));
	assign int_ok = (cur_ls == 48'd0) ||
		(now49 >= ({1'b0, cur_ls} + {17'd0, interval}));
	assign may = known && cfg.enable[item.domain] && !in_flight_q && gap_ok &&
		cur_ok && !(cur_live && (cur_cnt >= cfg.limit)) && int_ok;

	always_comb begin
		in_flight_n  = in_flight_q;
		flight_dom_n = flight_dom_q;
		last_any_n   = last_any_q;
		fail_inc     = '0;
		bo_raw       = '0;
		for (int i = 0; i < DOMAINS; i++) begin
			last_start_n[i]   = last_start_q[i];
			window_start_n[i] = window_start_q[i];
			window_count_n[i] = window_count_q[i];
			mode_n[i]         = mode_q[i];
			opened_n[i]       = opened_q[i];
			backoff_n[i]      = backoff_q[i];
			fail_n[i]         = fail_q[i];
		end
		case (item.op)
			OP_START: begin
				if (may) begin
					in_flight_n  = 1'b1;
					flight_dom_n = item.domain;
					last_any_n   = item.now_ms;
				end
				for (int i = 0; i < DOMAINS; i++) begin
					if (may && sel[i]) begin
						last_start_n[i] = item.now_ms;
						if (!win_live[i]) begin
							window_start_n[i] = item.now_ms;
							window_count_n[i] = 8'd1;
						end else if (window_count_q[i] != 8'hFF) begin
							window_count_n[i] = window_count_q[i] + 8'd1;
						end
						if (mode_q[i] == CIRC_OPEN) begin
							mode_n[i] = CIRC_HALF;
						end
					end
				end
			end
			OP_FINISH: begin
				if (known && in_flight_q && (flight_dom_q == item.domain)) begin
					in_flight_n = 1'b0;
				end
				for (int i = 0; i < DOMAINS; i++) begin
					if (sel[i]) begin
						if (item.success) begin
							fail_n[i]    = '0;
							mode_n[i]    = CIRC_CLOSED;
							opened_n[i]  = '0;
							backoff_n[i] = '0;
						end else begin
							fail_inc = (fail_q[i] == 16'hFFFF) ? fail_q[i] : fail_q[i] + 16'd1;
							fail_n[i] = fail_inc;
							if (fail_inc >= cfg.fail_open) begin
								bo_raw = (backoff_q[i] == 32'd0) ? {2'b00, cfg.base_bo} :
									{backoff_q[i], 1'b0};
								if (bo_raw > {2'b00, cfg.max_bo}) begin
									bo_raw = {2'b00, cfg.max_bo};
								end
								mode_n[i]    = CIRC_OPEN;
								opened_n[i]  = item.now_ms;
								backoff_n[i] = bo_raw[31:0];
							end
						end
					end
				end
			end
			OP_TICK: begin
				for (int i = 0; i < DOMAINS; i++) begin
					if ((mode_q[i] == CIRC_OPEN) && expired[i]) begin
						mode_n[i] = CIRC_HALF;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		rep_circ = CIRC_OPEN;
		rep_fail = '0;
		for (int i = 0; i < DOMAINS; i++) begin
			if (sel[i]) begin
				rep_circ = mode_n[i];
				rep_fail = fail_n[i];
			end
		end
	end

	assign result.allowed       = may && ((item.op == OP_QUERY) || (item.op == OP_START));
	assign result.circuit       = rep_circ;
	assign result.failure_count = rep_fail;
	assign result.busy_res      = in_flight_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DOMAINS; i++) begin
				last_start_q[i]   <= '0;
				window_start_q[i] <= '0;
				window_count_q[i] <= '0;
				mode_q[i]         <= CIRC_CLOSED;
				opened_q[i]       <= '0;
				backoff_q[i]      <= '0;
				fail_q[i]         <= '0;
			end
			in_flight_q  <= 1'b0;
			flight_dom_q <= '0;
			last_any_q   <= '0;
		end else if (step) begin
			for (int i = 0; i < DOMAINS; i++) begin
				last_start_q[i]   <= last_start_n[i];
				window_start_q[i] <= window_start_n[i];
				window_count_q[i] <= window_count_n[i];
				mode_q[i]         <= mode_n[i];
				opened_q[i]       <= opened_n[i];
				backoff_q[i]      <= backoff_n[i];
				fail_q[i]         <= fail_n[i];
			end
			in_flight_q  <= in_flight_n;
			flight_dom_q <= flight_dom_n;
			last_any_q   <= last_any_n;
		end
	end

endmodule

FILE: rtl/core/request_admission_circuit_breaker_top.sv
`timescale 1ns / 1ps
// Top level of the request admission block: input register, engine, result register.
// Depends on rac_pkg, rac_if, rac_cfg_regs and rac_engine.
//
// The block admits requests for up to four addressable domains, combining a
// per-domain circuit breaker with a 60000 ms fixed-window start limit, a
// per-domain minimum interval and a global gap between starts. It takes one
// item per clock cycle unless the result side stalls; an item passes from the
// input register through the engine into the result register, which offers
// its result until it is taken. While a result waits, the input register holds
// its item and the request side stalls. All domain state sits in flip-flops so
// that each item is decided and applied in the same cycle. The user must write
// configuration through the APB port only while no item is pending; the block
// itself does not enforce this. Register i lies at byte address 8*i.
module request_admission_circuit_breaker_top import rac_pkg::*; #(
	parameter int DOMAINS = DOMAINS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	rac_req_if.sink     req,
	rac_res_if.source   res
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	logic    advance;
	result_t result;
	result_t res_q;
	logic    res_valid_q;

	rac_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rac_engine #(
		.DOMAINS (DOMAINS)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (advance),
		.item   (item_s1),
		.result (result)
	);

	assign advance   = valid_s1 && (!res_valid_q || res.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.op      <= op_t'(req.op);
			item_s1.domain  <= req.domain;
			item_s1.success <= req.success;
			item_s1.now_ms  <= req.now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= result;
		end
	end

	assign res.valid         = res_valid_q;
	assign res.allowed       = res_q.allowed;
	assign res.circuit       = res_q.circuit;
	assign res.failure_count = res_q.failure_count;
	assign res.busy_res      = res_q.busy_res;

endmodule
